### sv/rssp_pkg.sv
// Shared types and constants of the sensor stream parser.
package rssp_pkg;

  // Framing and packet id codes
  localparam logic [7:0] HEADER_BYTE = 8'd19;
  localparam logic [7:0] ID_BUMP_CODE = 8'd7;
  localparam logic [7:0] ID_DIST_CODE = 8'd19;
  localparam logic [7:0] ID_ANGLE_CODE = 8'd20;
  localparam logic [7:0] ID_BUTTON_CODE = 8'd18;
  localparam logic [7:0] BUMP_MASK = 8'h03;
  localparam logic [7:0] PLAY_MASK = 8'h01;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_ID,
    PH_DATA,
    PH_CHECK
  } phase_t;

  // Packet kind decoded from an id byte
  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_BUMP,
    KIND_BUTTON,
    KIND_DIST,
    KIND_ANGLE
  } kind_t;

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_header;
    logic       is_zero;
    logic       bump_set;
    logic       play_set;
    kind_t      kind;
  } q_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] distance_total;
    logic [31:0] angle_total;
    logic [7:0]  bumper_flags;
    logic        bump_event;
    logic        play_event;
    logic        frame_end;
    logic        frame_error;
  } res_t;

endpackage

### sv/rssp_ifs.sv
// Handshake channel interfaces of the sensor stream parser.
interface rssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rssp_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] distance_total;
  logic signed [31:0] angle_total;
  logic [7:0]        bumper_flags;
  logic              bump_event;
  logic              play_event;
  logic              frame_end;
  logic              frame_error;

  modport source (output valid, output distance_total, output angle_total,
                  output bumper_flags, output bump_event, output play_event,
                  output frame_end, output frame_error, input ready);
  modport sink (input valid, input distance_total, input angle_total,
                input bumper_flags, input bump_event, input play_event,
                input frame_end, input frame_error, output ready);
endinterface

interface rssp_cfg_if;
  logic valid;
  logic ready;
  logic stream_enable;

  modport source (output valid, output stream_enable, input ready);
  modport sink (input valid, input stream_enable, output ready);
endinterface

### sv/rssp_front.sv
// Front end: accept stream bytes and classify them for the parser.
module rssp_front (
  rssp_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               push,
  output rssp_pkg::q_item_t  push_item
);
  import rssp_pkg::*;

  // Accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the byte for every role it may play
  always_comb begin
    push_item.rx_byte   = in_ch.rx_byte;
    push_item.is_header = (in_ch.rx_byte == HEADER_BYTE);
    push_item.is_zero   = (in_ch.rx_byte == 8'd0);
    push_item.bump_set  = ((in_ch.rx_byte & BUMP_MASK) != 8'd0);
    push_item.play_set  = ((in_ch.rx_byte & PLAY_MASK) != 8'd0);
    case (in_ch.rx_byte)
      ID_BUMP_CODE:   push_item.kind = KIND_BUMP;
      ID_BUTTON_CODE: push_item.kind = KIND_BUTTON;
      ID_DIST_CODE:   push_item.kind = KIND_DIST;
      ID_ANGLE_CODE:  push_item.kind = KIND_ANGLE;
      default:        push_item.kind = KIND_OTHER;
    endcase
  end

endmodule

### sv/rssp_queue.sv
// Short queue of classified items between front and back.
module rssp_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rssp_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output rssp_pkg::q_item_t q_item
);
  import rssp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/rssp_back.sv
// Back end: frame state machine, running totals and result register.
module rssp_back #(
  parameter int SUM_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stream_enable,
  input  logic              q_valid,
  input  rssp_pkg::q_item_t q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rssp_pkg::res_t    res
);
  import rssp_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          payload_left_r, payload_left_nxt;
  kind_t               kind_r, kind_nxt;
  logic                data_index_r, data_index_nxt;
  logic [7:0]          high_byte_r, high_byte_nxt;
  logic [SUM_BITS-1:0] dist_sum_r, dist_sum_nxt;
  logic [SUM_BITS-1:0] angle_sum_r, angle_sum_nxt;
  logic [7:0]          bumper_latch_r, bumper_latch_nxt;
  logic                bump_was_set_r, bump_was_set_nxt;
  logic                play_was_set_r, play_was_set_nxt;
  logic                error_latch_r, error_latch_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;
  logic [7:0]          left_dec;
  logic [SUM_BITS-1:0] delta;
  logic                done;
  logic                bump_ev;
  logic                play_ev;
  logic                fend;

  // Take the next item when the result slot is free or being drained
  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign left_dec  = payload_left_r - 8'd1;
  assign delta     = SUM_BITS'(signed'({high_byte_r, q_item.rx_byte}));

  // Next state and per-item flags
  always_comb begin
    phase_nxt        = phase_r;
    payload_left_nxt = payload_left_r;
    kind_nxt         = kind_r;
    data_index_nxt   = data_index_r;
    high_byte_nxt    = high_byte_r;
    dist_sum_nxt     = dist_sum_r;
    angle_sum_nxt    = angle_sum_r;
    bumper_latch_nxt = bumper_latch_r;
    bump_was_set_nxt = bump_was_set_r;
    play_was_set_nxt = play_was_set_r;
    error_latch_nxt  = error_latch_r;
    done             = 1'b1;
    bump_ev          = 1'b0;
    play_ev          = 1'b0;
    fend             = 1'b0;
    if (pop && !error_latch_r) begin
      if (!stream_enable) begin
        phase_nxt      = PH_HEADER;
        data_index_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (q_item.is_header) begin
              phase_nxt = PH_LENGTH;
            end else begin
              error_latch_nxt = 1'b1;
            end
          end
          PH_LENGTH: begin
            payload_left_nxt = q_item.rx_byte;
            data_index_nxt   = 1'b0;
            phase_nxt        = q_item.is_zero ? PH_CHECK : PH_ID;
          end
          PH_ID: begin
            kind_nxt         = q_item.kind;
            data_index_nxt   = 1'b0;
            payload_left_nxt = left_dec;
            phase_nxt        = (left_dec == 8'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            case (kind_r)
              KIND_BUMP: begin
                bump_ev          = q_item.bump_set && !bump_was_set_r;
                bump_was_set_nxt = q_item.bump_set;
                bumper_latch_nxt = q_item.rx_byte;
              end
              KIND_BUTTON: begin
                play_ev          = q_item.play_set && !play_was_set_r;
                play_was_set_nxt = q_item.play_set;
              end
              KIND_DIST, KIND_ANGLE: begin
                if (!data_index_r) begin
                  high_byte_nxt  = q_item.rx_byte;
                  data_index_nxt = 1'b1;
                  done           = 1'b0;
                end else begin
                  if (kind_r == KIND_DIST) begin
                    dist_sum_nxt = dist_sum_r + delta;
                  end else begin
                    angle_sum_nxt = angle_sum_r + delta;
                  end
                  data_index_nxt = 1'b0;
                end
              end
              default: begin
                // unknown id: skip its one data byte
              end
            endcase
            payload_left_nxt = left_dec;
            // cut a packet short at the payload's end
            if (left_dec == 8'd0) begin
              data_index_nxt = 1'b0;
              phase_nxt      = PH_CHECK;
            end else if (done) begin
              phase_nxt = PH_ID;
            end
          end
          PH_CHECK: begin
            fend      = 1'b1;
            phase_nxt = PH_HEADER;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
  end

  // Build the result item and the output valid
  always_comb begin
    res_nxt.distance_total = 32'(signed'(dist_sum_nxt));
    res_nxt.angle_total    = 32'(signed'(angle_sum_nxt));
    res_nxt.bumper_flags   = bumper_latch_nxt;
    res_nxt.bump_event     = bump_ev;
    res_nxt.play_event     = play_ev;
    res_nxt.frame_end      = fend;
    res_nxt.frame_error    = error_latch_nxt;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      payload_left_r <= '0;
      kind_r         <= KIND_OTHER;
      data_index_r   <= 1'b0;
      high_byte_r    <= '0;
      dist_sum_r     <= '0;
      angle_sum_r    <= '0;
      bumper_latch_r <= '0;
      bump_was_set_r <= 1'b0;
      play_was_set_r <= 1'b0;
      error_latch_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      payload_left_r <= payload_left_nxt;
      kind_r         <= kind_nxt;
      data_index_r   <= data_index_nxt;
      high_byte_r    <= high_byte_nxt;
      dist_sum_r     <= dist_sum_nxt;
      angle_sum_r    <= angle_sum_nxt;
      bumper_latch_r <= bumper_latch_nxt;
      bump_was_set_r <= bump_was_set_nxt;
      play_was_set_r <= play_was_set_nxt;
      error_latch_r  <= error_latch_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Load the result register on each taken item
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  // Error stays set until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_latch_r |=> error_latch_r)
    else $error("frame error latch cleared without reset");

  // A bump event always comes with a bumper bit set
  a_bump_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bump_event) |-> (res_r.bumper_flags[1:0] != 2'b00))
    else $error("bump event without bumper bit");

  // One byte raises at most one event
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({res_r.bump_event, res_r.play_event, res_r.frame_end}))
    else $error("more than one event on one item");

  // A checksum byte returns the parser to header search
  a_end_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && fend) |=> (phase_r == PH_HEADER))
    else $error("frame end did not return to header search");

endmodule

### sv/robot_sensor_stream_parser.sv
// Top level of the sensor stream parser.
//
// Usage: feed the received sensor stream one byte per item on in_ch. Each
// accepted byte yields exactly one result item on out_ch carrying the
// running distance and angle totals, the latest bumper flag byte, bump and
// play events, a frame end flag and the sticky frame error.
// cfg_ch writes stream_enable; it is always ready. While it is 0 bytes are
// consumed but ignored and the parser waits for a header.
// A byte accepted on in_ch is written into the front queue; the back end
// takes it when the result slot is free or being drained and loads the
// result register, which drives out_ch.valid.
// Throughput: one byte per cycle while out_ch does not stall.
// When out_ch stalls, the held result stays in the output register and
// the queue (QUEUE_DEPTH entries) absorbs bytes; in_ch.ready drops only
// when the queue is full.
// Reset (rst_n low, synchronous) clears the totals, flags, error, queue
// and stream_enable; the first result after reset reflects the first byte.
module robot_sensor_stream_parser #(
  parameter int SUM_BITS    = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  rssp_in_if.sink       in_ch,
  rssp_out_if.source    out_ch,
  rssp_cfg_if.sink      cfg_ch
);
  import rssp_pkg::*;

  logic     stream_enable_r;
  logic     q_full;
  logic     push;
  q_item_t  push_item;
  logic     pop;
  logic     q_valid;
  q_item_t  q_item;
  res_t     res;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_enable_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      stream_enable_r <= cfg_ch.stream_enable;
    end
  end

  rssp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rssp_back #(
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .stream_enable (stream_enable_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .res           (res)
  );

  // Drive the result channel
  assign out_ch.distance_total = res.distance_total;
  assign out_ch.angle_total    = res.angle_total;
  assign out_ch.bumper_flags   = res.bumper_flags;
  assign out_ch.bump_event     = res.bump_event;
  assign out_ch.play_event     = res.play_event;
  assign out_ch.frame_end      = res.frame_end;
  assign out_ch.frame_error    = res.frame_error;

endmodule

### tb/sv/tb_robot_sensor_stream_parser.sv
// Self-checking testbench of the sensor stream parser, with its own predictor.
`timescale 1ns / 1ps

module tb_robot_sensor_stream_parser;
  import rssp_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;

  rssp_in_if  in_ch ();
  rssp_out_if out_ch ();
  rssp_cfg_if cfg_ch ();

  robot_sensor_stream_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Idle rates in percent for the byte sender and the result receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int   mismatches = 0;
  int   bytes_taken = 0;
  res_t pending_reports[$];

  // Predicted parser state
  logic        pr_enable = 1'b0;
  phase_t      pr_phase = PH_HEADER;
  logic [7:0]  pr_left = '0;
  logic [7:0]  pr_id = '0;
  logic        pr_low_next = 1'b0;
  logic [7:0]  pr_high = '0;
  logic [31:0] pr_dist = '0;
  logic [31:0] pr_angle = '0;
  logic [7:0]  pr_bumper = '0;
  logic        pr_bump_set = 1'b0;
  logic        pr_play_set = 1'b0;
  logic        pr_error = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the parser by one byte and return the report it should produce
  function automatic res_t decode_stream_byte(input logic [7:0] b);
    res_t  r;
    logic  done;
    r = '0;
    done = 1'b1;
    if (!pr_error) begin
      if (!pr_enable) begin
        pr_phase = PH_HEADER;
        pr_low_next = 1'b0;
      end else begin
        case (pr_phase)
          PH_HEADER: begin
            if (b == HEADER_BYTE) pr_phase = PH_LENGTH;
            else pr_error = 1'b1;
          end
          PH_LENGTH: begin
            pr_left = b;
            pr_low_next = 1'b0;
            if (b == 8'd0) pr_phase = PH_CHECK;
            else pr_phase = PH_ID;
          end
          PH_ID: begin
            pr_id = b;
            pr_low_next = 1'b0;
            pr_left = pr_left - 8'd1;
            if (pr_left == 8'd0) pr_phase = PH_CHECK;
            else pr_phase = PH_DATA;
          end
          PH_DATA: begin
            if (pr_id == ID_BUMP_CODE) begin
              if ((b & BUMP_MASK) != 0 && !pr_bump_set) r.bump_event = 1'b1;
              pr_bump_set = (b & BUMP_MASK) != 0;
              pr_bumper = b;
            end else if (pr_id == ID_BUTTON_CODE) begin
              if ((b & PLAY_MASK) != 0 && !pr_play_set) r.play_event = 1'b1;
              pr_play_set = (b & PLAY_MASK) != 0;
            end else if (pr_id == ID_DIST_CODE || pr_id == ID_ANGLE_CODE) begin
              if (!pr_low_next) begin
                pr_high = b;
                pr_low_next = 1'b1;
                done = 1'b0;
              end else begin
                // Sign-extend the big-endian word and wrap into the total
                if (pr_id == ID_DIST_CODE)
                  pr_dist = pr_dist + {{16{pr_high[7]}}, pr_high, b};
                else
                  pr_angle = pr_angle + {{16{pr_high[7]}}, pr_high, b};
                pr_low_next = 1'b0;
              end
            end
            pr_left = pr_left - 8'd1;
            if (pr_left == 8'd0) begin
              pr_low_next = 1'b0;
              pr_phase = PH_CHECK;
            end else if (done) begin
              pr_phase = PH_ID;
            end
          end
          PH_CHECK: begin
            r.frame_end = 1'b1;
            pr_phase = PH_HEADER;
          end
          default: pr_phase = PH_HEADER;
        endcase
      end
    end
    r.distance_total = pr_dist;
    r.angle_total = pr_angle;
    r.bumper_flags = pr_bumper;
    r.frame_error = pr_error;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each report, track config writes and predict each accepted byte
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report arrived with no byte waiting for one");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("distance_total", want.distance_total, out_ch.distance_total);
          check_field("angle_total", want.angle_total, out_ch.angle_total);
          check_field("bumper_flags", 32'(want.bumper_flags), 32'(out_ch.bumper_flags));
          check_field("bump_event", 32'(want.bump_event), 32'(out_ch.bump_event));
          check_field("play_event", 32'(want.play_event), 32'(out_ch.play_event));
          check_field("frame_end", 32'(want.frame_end), 32'(out_ch.frame_end));
          check_field("frame_error", 32'(want.frame_error), 32'(out_ch.frame_error));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) pr_enable = cfg_ch.stream_enable;
      if (in_ch.valid && in_ch.ready) begin
        pending_reports.push_back(decode_stream_byte(in_ch.rx_byte));
        bytes_taken++;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no channel moves an item for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Send one byte; called and returning just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Write stream_enable once every pending report has come back
  task automatic write_stream_enable(input logic value);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.stream_enable <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Emit one well-formed frame with random packets; the last may be cut short
  task automatic send_random_frame();
    int         pick;
    int         left;
    int         n;
    logic [7:0] id;
    pick = $urandom_range(19);
    if (pick == 0) left = 0;
    else if (pick == 1) left = $urandom_range(100, 255);
    else left = $urandom_range(1, 14);
    send_byte(HEADER_BYTE);
    send_byte(8'(left));
    while (left > 0) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1: id = ID_BUMP_CODE;
        2, 3: id = ID_BUTTON_CODE;
        4, 5: id = ID_DIST_CODE;
        6, 7: id = ID_ANGLE_CODE;
        default: id = 8'($urandom_range(255));
      endcase
      send_byte(id);
      left--;
      n = (id == ID_DIST_CODE || id == ID_ANGLE_CODE) ? 2 : 1;
      while (n > 0 && left > 0) begin
        // Favor small flag bytes so edges toggle both ways
        if ((id == ID_BUMP_CODE || id == ID_BUTTON_CODE) && $urandom_range(1) == 0)
          send_byte(8'($urandom_range(3)));
        else
          send_byte(8'($urandom_range(255)));
        n--;
        left--;
      end
    end
    send_byte(8'($urandom_range(255)));
  endtask

  // Bytes while disabled are dropped; disabling mid-frame restarts at the header
  task automatic test_stream_disable();
    send_byte(8'h13);
    send_byte(8'h00);
    send_byte(8'hFF);
    write_stream_enable(1'b1);
    send_byte(HEADER_BYTE);
    send_byte(8'd5);
    send_byte(ID_DIST_CODE);
    send_byte(8'h12);
    write_stream_enable(1'b0);
    send_byte(8'h05);
    send_byte(8'h13);
    write_stream_enable(1'b1);
    // Zero payload length: next byte is the checksum
    send_byte(HEADER_BYTE);
    send_byte(8'd0);
    send_byte(8'hFF);
    send_byte(HEADER_BYTE);
    send_byte(8'd2);
    send_byte(ID_BUMP_CODE);
    send_byte(8'h02);
    send_byte(8'h77);
  endtask

  // Extreme words, every packet kind and both ways to cut a packet short
  task automatic test_directed_frames();
    send_byte(HEADER_BYTE);
    send_byte(8'd14);
    send_byte(ID_DIST_CODE);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(ID_ANGLE_CODE);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(ID_BUMP_CODE);
    send_byte(8'h00);
    send_byte(ID_BUMP_CODE);
    send_byte(8'h01);
    send_byte(ID_BUTTON_CODE);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Word packet with only its high byte inside the payload
    send_byte(HEADER_BYTE);
    send_byte(8'd2);
    send_byte(ID_DIST_CODE);
    send_byte(8'hFF);
    send_byte(8'hA5);
    // Id byte with no data inside the payload
    send_byte(HEADER_BYTE);
    send_byte(8'd1);
    send_byte(ID_ANGLE_CODE);
    send_byte(8'h3C);
  endtask

  // Random frames, with now and then a frame abandoned by disabling the stream
  task automatic test_random_frames(input int count);
    int start;
    int k;
    start = bytes_taken;
    while (bytes_taken - start < count) begin
      if ($urandom_range(24) == 0) begin
        send_byte(HEADER_BYTE);
        send_byte(8'($urandom_range(1, 255)));
        for (k = $urandom_range(3); k > 0; k--) send_byte(8'($urandom_range(255)));
        write_stream_enable(1'b0);
        for (k = $urandom_range(1, 4); k > 0; k--) send_byte(8'($urandom_range(255)));
        write_stream_enable(1'b1);
      end else begin
        send_random_frame();
      end
    end
  endtask

  // Wrong header latches the error; it survives a disable and later frames
  task automatic test_header_error();
    logic [7:0] bad;
    do bad = 8'($urandom_range(255)); while (bad == HEADER_BYTE);
    send_byte(bad);
    send_byte(HEADER_BYTE);
    send_byte(8'd2);
    send_byte(ID_BUMP_CODE);
    send_byte(8'h03);
    send_byte(8'h00);
    write_stream_enable(1'b0);
    send_byte(8'h13);
    write_stream_enable(1'b1);
    send_byte(HEADER_BYTE);
    send_byte(8'd0);
    send_byte(8'hFF);
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.stream_enable = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_stall_pct = 60;
    test_stream_disable();
    test_directed_frames();
    test_random_frames(600);

    send_idle_pct = 60;
    recv_stall_pct = 38;
    test_random_frames(600);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_frames(600);
    test_header_error();

    // Drain the reports, then allow the pipeline to settle
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
